>>> design/swct_pkg.sv
// Package with the constants and types shared by the sorted word count table.
package swct_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned OUT_CNT_W = 16;
  localparam int unsigned DIST_W    = 7;

  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TOTAL_W = $clog2(DEPTH + 1);

  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [TOTAL_W-1:0]    total_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  // Request codes carried in req_type.
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_DUMP = 1'b1;

  // One table entry as held in the memory.
  typedef struct packed {
    key_t   key;
    count_t count;
  } entry_t;

endpackage

>>> design/swct_if.sv
// Handshake interfaces for the request and result channels of the table.
interface swct_req_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [swct_pkg::KEY_W-1:0] word_key;

  modport source (output valid, req_type, word_key, input ready);
  modport sink   (input valid, req_type, word_key, output ready);
endinterface

interface swct_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [swct_pkg::KEY_W-1:0]     entry_word;
  logic [swct_pkg::OUT_CNT_W-1:0] entry_count;
  logic [swct_pkg::DIST_W-1:0]    distinct_words;
  logic                         table_full;
  logic                         list_empty;
  logic                         last;

  modport source (output valid, entry_word, entry_count, distinct_words, table_full,
                  list_empty, last, input ready);
  modport sink   (input valid, entry_word, entry_count, distinct_words, table_full,
                  list_empty, last, output ready);
endinterface

>>> design/sorted_word_count_table.sv
// Top level of the sorted word count table: memory, sequencer and result register.
//
//   Channel  Port   Dir  Payload
//   -------  -----  ---  ----------------------------------------------------------
//   request  req_i  in   req_type, word_key
//   result   rsp_o  out  entry_word, entry_count, distinct_words, table_full,
//                        list_empty, last
//
// One item is worked on at a time; the table memory sets the pace. An add scans
// the entries in turn from entry 0, and an insert moves each entry above the
// insert position up one slot. A dump reads and emits each entry in turn. Reset
// clears the state, indices, entry total and result valid but not the memory;
// only entries below the total are ever read. A stalled result holds the sequencer
// where it must load a result; the result register lets a new item in early.
module sorted_word_count_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  swct_req_if.sink   req_i,
  swct_rsp_if.source rsp_o
);
  import swct_pkg::*;

  // Sequencer states. SCAN walks up from entry 0 looking for the first key not
  // below the new one; PLACE/SHIFT_WR then move entries up one slot from the top
  // down until the insert position is free.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PLACE,
    S_SHIFT_WR,
    S_DUMP_RD,
    S_DUMP_EMIT
  } state_e;

  // Table memory: one write port, one read port with a registered read.
  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  logic   mem_we;
  idx_t   mem_waddr;
  entry_t mem_wdata;
  logic   mem_re;
  idx_t   mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // Control state and result register.
  state_e st_q, st_d;
  key_t   key_q, key_d;
  total_t idx_q, idx_d;
  total_t pos_q, pos_d;
  total_t total_q, total_d;

  logic                 out_valid_q, out_valid_d;
  key_t                 out_word_q, out_word_d;
  logic [OUT_CNT_W-1:0] out_count_q, out_count_d;
  logic [DIST_W-1:0]    out_dist_q, out_dist_d;
  logic                 out_full_q, out_full_d;
  logic                 out_empty_q, out_empty_d;
  logic                 out_last_q, out_last_d;

  logic   out_free;
  logic   out_load;
  total_t idx_p1;
  total_t idx_m1;
  total_t total_p1;
  count_t cnt_inc;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign idx_p1   = idx_q + total_t'(1);
  assign idx_m1   = idx_q - total_t'(1);
  assign total_p1 = total_q + total_t'(1);
  // A count that has reached the top stays there.
  assign cnt_inc  = (rd_data_q.count == COUNT_MAX) ? rd_data_q.count
                                                   : rd_data_q.count + count_t'(1);

  assign req_i.ready = (st_q == S_IDLE);

  always_comb begin
    st_d        = st_q;
    key_d       = key_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    total_d     = total_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[IDX_W-1:0];
    mem_wdata   = rd_data_q;
    mem_re      = 1'b0;
    mem_raddr   = idx_q[IDX_W-1:0];
    out_load    = 1'b0;
    out_word_d  = out_word_q;
    out_count_d = out_count_q;
    out_dist_d  = out_dist_q;
    out_full_d  = 1'b0;
    out_empty_d = 1'b0;
    out_last_d  = 1'b1;

    unique case (st_q)
      S_IDLE: begin
        if (req_i.valid) begin
          key_d = req_i.word_key;
          idx_d = '0;
          pos_d = '0;
          if (req_i.req_type == REQ_DUMP) begin
            st_d = S_DUMP_RD;
          end else if (total_q == '0) begin
            st_d = S_PLACE;
          end else begin
            st_d = S_SCAN_RD;
          end
        end
      end

      S_SCAN_RD: begin
        mem_re = 1'b1;
        st_d   = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (rd_data_q.key == key_q) begin
          // Known word: bump its count in place and report it.
          if (out_free) begin
            mem_we          = 1'b1;
            mem_wdata.key   = key_q;
            mem_wdata.count = cnt_inc;
            out_load        = 1'b1;
            out_word_d      = key_q;
            out_count_d     = OUT_CNT_W'(cnt_inc);
            out_dist_d      = DIST_W'(total_q);
            st_d            = S_IDLE;
          end
        end else if (rd_data_q.key > key_q) begin
          pos_d = idx_q;
          idx_d = total_q;
          st_d  = S_PLACE;
        end else if (idx_p1 == total_q) begin
          // Every stored key is below the new one: it goes at the end.
          pos_d = total_q;
          idx_d = total_q;
          st_d  = S_PLACE;
        end else begin
          idx_d = idx_p1;
          st_d  = S_SCAN_RD;
        end
      end

      S_PLACE: begin
        if (total_q == total_t'(DEPTH)) begin
          // No room for a new word: drop it and flag the drop.
          if (out_free) begin
            out_load    = 1'b1;
            out_word_d  = key_q;
            out_count_d = '0;
            out_dist_d  = DIST_W'(total_q);
            out_full_d  = 1'b1;
            st_d        = S_IDLE;
          end
        end else if (idx_q == pos_q) begin
          if (out_free) begin
            mem_we          = 1'b1;
            mem_waddr       = pos_q[IDX_W-1:0];
            mem_wdata.key   = key_q;
            mem_wdata.count = count_t'(1);
            total_d         = total_p1;
            out_load        = 1'b1;
            out_word_d      = key_q;
            out_count_d     = OUT_CNT_W'(1);
            out_dist_d      = DIST_W'(total_p1);
            st_d            = S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_m1[IDX_W-1:0];
          st_d      = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[IDX_W-1:0];
        mem_wdata = rd_data_q;
        idx_d     = idx_m1;
        st_d      = S_PLACE;
      end

      S_DUMP_RD: begin
        if (total_q == '0) begin
          if (out_free) begin
            out_load    = 1'b1;
            out_word_d  = '0;
            out_count_d = '0;
            out_dist_d  = '0;
            out_empty_d = 1'b1;
            st_d        = S_IDLE;
          end
        end else begin
          mem_re = 1'b1;
          st_d   = S_DUMP_EMIT;
        end
      end

      S_DUMP_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_word_d  = rd_data_q.key;
          out_count_d = OUT_CNT_W'(rd_data_q.count);
          out_dist_d  = DIST_W'(total_q);
          out_last_d  = (idx_p1 == total_q);
          if (idx_p1 == total_q) begin
            st_d = S_IDLE;
          end else begin
            idx_d = idx_p1;
            st_d  = S_DUMP_RD;
          end
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      idx_q       <= '0;
      pos_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (out_load) begin
      out_word_q  <= out_word_d;
      out_count_q <= out_count_d;
      out_dist_q  <= out_dist_d;
      out_full_q  <= out_full_d;
      out_empty_q <= out_empty_d;
      out_last_q  <= out_last_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.entry_word     = out_word_q;
  assign rsp_o.entry_count    = out_count_q;
  assign rsp_o.distinct_words = out_dist_q;
  assign rsp_o.table_full     = out_full_q;
  assign rsp_o.list_empty     = out_empty_q;
  assign rsp_o.last           = out_last_q;

endmodule

>>> design/swct_checker.sv
// Port-level checker for the sorted word count table and its bind statement.
module swct_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [swct_pkg::KEY_W-1:0]     entry_word,
  input logic [swct_pkg::OUT_CNT_W-1:0] entry_count,
  input logic [swct_pkg::DIST_W-1:0]    distinct_words,
  input logic                           table_full,
  input logic                           list_empty,
  input logic                           last
);
  import swct_pkg::*;

  // A stalled result keeps its word, count and last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(entry_word) && $stable(entry_count)
      && $stable(last))
    else $error("result changed while stalled");

  // An empty dump is a lone, all-zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && list_empty |-> last && !table_full && entry_word == '0
      && entry_count == '0 && distinct_words == '0)
    else $error("malformed empty dump result");

  // A dropped word reports a zero count, a full table and ends its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && table_full |-> last && entry_count == '0
      && distinct_words == DIST_W'(DEPTH))
    else $error("malformed table full result");

  // Outside the empty dump, every result comes from a table holding words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !list_empty |-> distinct_words != '0
      && distinct_words <= DIST_W'(DEPTH))
    else $error("distinct word count out of range");

endmodule

bind sorted_word_count_table swct_checker u_swct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (rsp_o.valid),
  .out_ready      (rsp_o.ready),
  .entry_word     (rsp_o.entry_word),
  .entry_count    (rsp_o.entry_count),
  .distinct_words (rsp_o.distinct_words),
  .table_full     (rsp_o.table_full),
  .list_empty     (rsp_o.list_empty),
  .last           (rsp_o.last)
);

>>> dv/tb_sorted_word_count_table.sv
// Self-checking testbench for the sorted word count table, with random handshake gaps.
module tb_sorted_word_count_table;
  timeunit 1ns;
  timeprecision 1ps;

  import swct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned LONG_STALL  = 400;
  localparam int unsigned TAIL_CYCLES = 4 * DEPTH + 40;
  localparam int unsigned POOL_SIZE   = 96;
  localparam int unsigned PRINT_MAX   = 30;

  // One request as queued for the driver.
  typedef struct packed {
    logic req_type;
    key_t word_key;
  } word_req_t;

  // One result as the block should present it.
  typedef struct packed {
    key_t                 word;
    logic [OUT_CNT_W-1:0] cnt;
    logic [DIST_W-1:0]    dwords;
    logic                 full;
    logic                 empty;
    logic                 last;
  } word_rsp_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  swct_req_if req_bus ();
  swct_rsp_if rsp_bus ();

  sorted_word_count_table dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the table, updated as each request is accepted.
  key_t        shadow_key [DEPTH];
  count_t      shadow_cnt [DEPTH];
  int unsigned shadow_total;

  word_req_t   pending_req_q [$];
  word_rsp_t   rsp_expected_q [$];

  int unsigned mismatches;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned drops_seen;
  int unsigned saturated_seen;
  int unsigned dumps_seen;
  int unsigned cycle_count;

  // The stimulus raises these to ask for a long receiver stall; the receiver serves them.
  int unsigned stall_requests;
  int unsigned stall_served;
  bit          no_idle;

  int unsigned tx_wait;
  int unsigned rx_wait;
  int unsigned rx_gap;

  key_t word_pool [POOL_SIZE];

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= PRINT_MAX)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Gap lengths: mostly none, some short, a few long.
  function automatic int unsigned pick_gap(int unsigned idle_pct);
    if (no_idle) return 0;
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(50, 15);
    return $urandom_range(4, 1);
  endfunction

  function automatic key_t pack_word(string s);
    key_t k;
    k = '0;
    for (int i = 0; i < 8 && i < s.len(); i++) begin
      k[63-8*i -: 8] = s[i];
    end
    return k;
  endfunction

  function automatic key_t random_word();
    key_t        k;
    int unsigned n;
    k = '0;
    n = $urandom_range(8, 1);
    for (int i = 0; i < n; i++) begin
      k[63-8*i -: 8] = 8'h41 + 8'($urandom_range(25));
    end
    return k;
  endfunction

  // Fill words share a prefix and differ in the last two letters.
  function automatic key_t fill_word(int unsigned n);
    key_t k;
    k = pack_word("FILL");
    k[31:24] = 8'h41 + 8'((n / 26) % 26);
    k[23:16] = 8'h41 + 8'(n % 26);
    return k;
  endfunction

  // Apply one accepted request to the shadow table and queue the results it causes.
  function automatic void track_request(logic req_type, key_t word_key);
    word_rsp_t   r;
    int unsigned pos;
    if (req_type == REQ_DUMP) begin
      dumps_seen++;
      if (shadow_total == 0) begin
        r = '{word: '0, cnt: '0, dwords: '0, full: 1'b0, empty: 1'b1, last: 1'b1};
        rsp_expected_q.push_back(r);
        return;
      end
      for (int unsigned i = 0; i < shadow_total; i++) begin
        r = '{word: shadow_key[i], cnt: OUT_CNT_W'(shadow_cnt[i]),
              dwords: DIST_W'(shadow_total), full: 1'b0, empty: 1'b0,
              last: (i + 1 == shadow_total)};
        rsp_expected_q.push_back(r);
      end
      return;
    end

    // First entry whose key is not below the new word.
    pos = 0;
    while (pos < shadow_total && shadow_key[pos] < word_key) pos++;

    if (pos < shadow_total && shadow_key[pos] == word_key) begin
      if (shadow_cnt[pos] != COUNT_MAX) shadow_cnt[pos] = shadow_cnt[pos] + 1'b1;
      r = '{word: word_key, cnt: OUT_CNT_W'(shadow_cnt[pos]),
            dwords: DIST_W'(shadow_total), full: 1'b0, empty: 1'b0, last: 1'b1};
    end else if (shadow_total >= DEPTH) begin
      r = '{word: word_key, cnt: '0, dwords: DIST_W'(shadow_total),
            full: 1'b1, empty: 1'b0, last: 1'b1};
    end else begin
      for (int unsigned j = shadow_total; j > pos; j--) begin
        shadow_key[j] = shadow_key[j-1];
        shadow_cnt[j] = shadow_cnt[j-1];
      end
      shadow_key[pos] = word_key;
      shadow_cnt[pos] = count_t'(1);
      shadow_total++;
      r = '{word: word_key, cnt: OUT_CNT_W'(1), dwords: DIST_W'(shadow_total),
            full: 1'b0, empty: 1'b0, last: 1'b1};
    end
    rsp_expected_q.push_back(r);
  endfunction

  task automatic check_result();
    word_rsp_t want;
    if (rsp_expected_q.size() == 0) begin
      report_mismatch("result with nothing expected", '0, rsp_bus.entry_word);
      return;
    end
    want = rsp_expected_q.pop_front();
    results_checked++;
    if (rsp_bus.entry_word !== want.word)
      report_mismatch("entry_word", want.word, rsp_bus.entry_word);
    if (rsp_bus.entry_count !== want.cnt)
      report_mismatch("entry_count", 64'(want.cnt), 64'(rsp_bus.entry_count));
    if (rsp_bus.distinct_words !== want.dwords)
      report_mismatch("distinct_words", 64'(want.dwords), 64'(rsp_bus.distinct_words));
    if (rsp_bus.table_full !== want.full)
      report_mismatch("table_full", 64'(want.full), 64'(rsp_bus.table_full));
    if (rsp_bus.list_empty !== want.empty)
      report_mismatch("list_empty", 64'(want.empty), 64'(rsp_bus.list_empty));
    if (rsp_bus.last !== want.last)
      report_mismatch("last", 64'(want.last), 64'(rsp_bus.last));
    if (want.full) drops_seen++;
    if (want.cnt == OUT_CNT_W'(COUNT_MAX) && !want.full) saturated_seen++;
  endtask

  // Driver: records each accepted item, then offers the next after a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        items_accepted++;
        track_request(req_bus.req_type, req_bus.word_key);
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          req_bus.valid <= 1'b0;
        end else if (pending_req_q.size() > 0) begin
          word_req_t nxt;
          nxt = pending_req_q.pop_front();
          req_bus.valid    <= 1'b1;
          req_bus.req_type <= nxt.req_type;
          req_bus.word_key <= nxt.word_key;
          tx_wait = pick_gap(40);
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and moves ready with random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) check_result();
      if (stall_served != stall_requests) begin
        stall_served++;
        rx_wait = LONG_STALL - 1;
        rsp_bus.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rx_gap = pick_gap(30);
        if (rx_gap > 0) begin
          rx_wait = rx_gap - 1;
          rsp_bus.ready <= 1'b0;
        end else begin
          rsp_bus.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, rsp_expected_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_add(key_t k);
    pending_req_q.push_back('{req_type: REQ_ADD, word_key: k});
  endtask

  task automatic queue_dump();
    pending_req_q.push_back('{req_type: REQ_DUMP, word_key: key_t'({$urandom, $urandom})});
  endtask

  // The sender holds back until the block has answered everything.
  task automatic wait_drained();
    while (pending_req_q.size() != 0 || req_bus.valid || rsp_expected_q.size() != 0)
      @(posedge clk);
  endtask

  // Random dumps and adds; most adds draw from the front of the word pool, so repeats are common.
  task automatic queue_mixed(int unsigned n, int unsigned dump_pct);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < dump_pct) queue_dump();
      else if (r < dump_pct + 6) queue_add(key_t'({$urandom, $urandom}));
      else if (r < dump_pct + 30) queue_add(word_pool[$urandom_range(POOL_SIZE - 1)]);
      else queue_add(word_pool[$urandom_range(39)]);
    end
  endtask

  initial begin
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_ADD;
    req_bus.word_key = '0;
    rsp_bus.ready    = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) word_pool[i] = random_word();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty dump, first insert, duplicate of a lone entry, insert ahead
    // of the first entry, the empty word, the largest key and alternating bit patterns.
    queue_dump();
    queue_add(pack_word("M"));
    queue_add(pack_word("M"));
    queue_add(pack_word("A"));
    queue_add('0);
    queue_add('1);
    queue_add(pack_word("ZZZZZZZZ"));
    queue_add(pack_word("MM"));
    queue_add(pack_word("A"));
    queue_add('1);
    queue_dump();
    queue_add({32{2'b01}});
    queue_add({32{2'b10}});
    queue_add(pack_word("ZZZZZZZY"));
    queue_add(pack_word("B"));
    queue_dump();
    wait_drained();

    // Random traffic while the receiver holds off long enough for the input to back up.
    stall_requests++;
    queue_mixed(40, 10);
    wait_drained();

    // Fill the table, then dump it whole behind a long receiver stall.
    for (int unsigned i = 0; i < 70; i++) queue_add(fill_word(i));
    wait_drained();
    stall_requests++;
    queue_dump();
    wait_drained();

    // A full table: repeats still count, new words are dropped.
    no_idle = 1'b1;
    queue_mixed(15, 5);
    no_idle = 1'b0;
    for (int unsigned i = 0; i < 10; i++) queue_add(fill_word(100 + $urandom_range(200)));
    queue_mixed(15, 8);
    queue_dump();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    while (rsp_expected_q.size() != 0) begin
      word_rsp_t left;
      left = rsp_expected_q.pop_front();
      report_mismatch("result never seen", left.word, '0);
    end

    $display("Covered %0d requests (%0d dumps) and %0d checked results over %0d cycles.",
             items_accepted, dumps_seen, results_checked, cycle_count);
    $display("Saw %0d dropped words on a full table and %0d results at the count ceiling.",
             drops_seen, saturated_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sorted_word_count_table.f
design/swct_pkg.sv
design/swct_if.sv
design/sorted_word_count_table.sv
design/swct_checker.sv
dv/tb_sorted_word_count_table.sv
